@@ hw/rtl/hsvrgb_pkg.sv @@
// Shared widths, codes and helper functions for the HSV to RGB565 level scaler.
package hsvrgb_pkg;

  localparam int HueW = 16;
  localparam int SvW = 9;
  localparam int PctW = 7;
  localparam int ChW = 8;
  localparam int Rgb565W = 16;

  localparam int HsvStages = 4;
  localparam int ScaleStages = 6;
  localparam int NumStages = HsvStages + ScaleStages;

  localparam logic [SvW-1:0] FullSv = SvW'(256);
  localparam logic [PctW-1:0] FullPct = PctW'(100);

  localparam logic [2:0] SecRedYel = 3'd0;
  localparam logic [2:0] SecYelGrn = 3'd1;
  localparam logic [2:0] SecGrnCyn = 3'd2;
  localparam logic [2:0] SecCynBlu = 3'd3;
  localparam logic [2:0] SecBluMag = 3'd4;

  function automatic logic [SvW-1:0] sv_clamp(input logic [SvW-1:0] x);
    return (x > FullSv) ? FullSv : x;
  endfunction

  function automatic logic [PctW-1:0] pct_clamp(input logic [PctW-1:0] x);
    return (x > FullPct) ? FullPct : x;
  endfunction

endpackage

@@ hw/rtl/hsvrgb_if.sv @@
// Request channel interfaces for the HSV input and the RGB565 result.
interface hsvrgb_in_if;
  import hsvrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue_frac;
  logic [SvW-1:0]   sat_level;
  logic [SvW-1:0]   val_level;
  logic [PctW-1:0]  level_pct;

  modport source (output valid, hue_frac, sat_level, val_level, level_pct, input ready);
  modport sink (input valid, hue_frac, sat_level, val_level, level_pct, output ready);
endinterface

interface hsvrgb_out_if;
  import hsvrgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [Rgb565W-1:0] packed_color;
  logic [ChW-1:0]     red_out;
  logic [ChW-1:0]     green_out;
  logic [ChW-1:0]     blue_out;
  logic [ChW-1:0]     bright_byte;

  modport source (output valid, packed_color, red_out, green_out, blue_out, bright_byte,
                  input ready);
  modport sink (input valid, packed_color, red_out, green_out, blue_out, bright_byte,
                output ready);
endinterface

@@ hw/rtl/hsvrgb_convert.sv @@
// Four-stage HSV to RGB conversion by the six-sector method, packed to RGB565.
module hsvrgb_convert (
  input  logic                             clk_i,
  input  logic [hsvrgb_pkg::HsvStages-1:0] adv_i,
  input  logic [hsvrgb_pkg::HueW-1:0]      hue_frac_i,
  input  logic [hsvrgb_pkg::SvW-1:0]       sat_level_i,
  input  logic [hsvrgb_pkg::SvW-1:0]       val_level_i,
  output logic [hsvrgb_pkg::Rgb565W-1:0]   packed_color_o,
  output logic [4:0]                       red5_o,
  output logic [5:0]                       green6_o,
  output logic [4:0]                       blue5_o
);
  import hsvrgb_pkg::*;

  localparam logic [24:0] OneQ24 = 25'h100_0000;

  logic [18:0]    h6;
  logic [2:0]     sec1_q, sec2_q, sec3_q;
  logic [15:0]    f1_q;
  logic [SvW-1:0] s1_q, v1_q, v2_q;

  logic [16:0]    nf;
  logic [16:0]    vx;
  logic [24:0]    fs2_q, gs2_q;
  logic [16:0]    vp2_q;
  logic [7:0]     cv2_q, cv3_q;

  logic [24:0]    qa, ta;
  logic [23:0]    px;
  logic [32:0]    vq3_q, vt3_q;
  logic [7:0]     cp3_q;

  logic [40:0]    qx, tx;
  logic [7:0]     cq, ct, r, g, b;
  logic [Rgb565W-1:0] packed_q;
  logic [4:0]     red5_q, blue5_q;
  logic [5:0]     green6_q;

  assign h6 = 19'(hue_frac_i) * 19'd6;

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      sec1_q <= h6[18:16];
      f1_q   <= h6[15:0];
      s1_q   <= sv_clamp(sat_level_i);
      v1_q   <= sv_clamp(val_level_i);
    end
  end

  assign nf = 17'h1_0000 - 17'(f1_q);
  assign vx = 17'(v1_q) * 17'd255;

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      fs2_q  <= 25'(f1_q) * 25'(s1_q);
      gs2_q  <= 25'(nf) * 25'(s1_q);
      vp2_q  <= 17'(v1_q) * (17'(FullSv) - 17'(s1_q));
      cv2_q  <= vx[15:8];
      v2_q   <= v1_q;
      sec2_q <= sec1_q;
    end
  end

  assign qa = OneQ24 - fs2_q;
  assign ta = OneQ24 - gs2_q;
  assign px = 24'(vp2_q) * 24'd255;

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      vq3_q  <= 33'(v2_q) * 33'(qa);
      vt3_q  <= 33'(v2_q) * 33'(ta);
      cp3_q  <= px[23:16];
      cv3_q  <= cv2_q;
      sec3_q <= sec2_q;
    end
  end

  assign qx = 41'(vq3_q) * 41'd255;
  assign tx = 41'(vt3_q) * 41'd255;
  assign cq = qx[39:32];
  assign ct = tx[39:32];

  always_comb begin
    unique case (sec3_q)
      SecRedYel: begin r = cv3_q; g = ct;    b = cp3_q; end
      SecYelGrn: begin r = cq;    g = cv3_q; b = cp3_q; end
      SecGrnCyn: begin r = cp3_q; g = cv3_q; b = ct;    end
      SecCynBlu: begin r = cp3_q; g = cq;    b = cv3_q; end
      SecBluMag: begin r = ct;    g = cp3_q; b = cv3_q; end
      default:   begin r = cv3_q; g = cp3_q; b = cq;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      packed_q <= {r[7:3], g[7:2], b[7:3]};
      red5_q   <= r[7:3];
      green6_q <= g[7:2];
      blue5_q  <= b[7:3];
    end
  end

  assign packed_color_o = packed_q;
  assign red5_o         = red5_q;
  assign green6_o       = green6_q;
  assign blue5_o        = blue5_q;

endmodule

@@ hw/rtl/hsvrgb_scale.sv @@
// Six-stage expansion of the 5/6/5 channels to bytes, scaling by the level percent, and the brightness byte.
module hsvrgb_scale (
  input  logic                               clk_i,
  input  logic [hsvrgb_pkg::ScaleStages-1:0] adv_i,
  input  logic [4:0]                         red5_i,
  input  logic [5:0]                         green6_i,
  input  logic [4:0]                         blue5_i,
  input  logic [hsvrgb_pkg::PctW-1:0]        level_pct_i,
  output logic [hsvrgb_pkg::ChW-1:0]         red_out_o,
  output logic [hsvrgb_pkg::ChW-1:0]         green_out_o,
  output logic [hsvrgb_pkg::ChW-1:0]         blue_out_o,
  output logic [hsvrgb_pkg::ChW-1:0]         bright_byte_o
);
  import hsvrgb_pkg::*;

  localparam int NumCh = 3;
  localparam int NumLanes = NumCh + 1;
  localparam int GreenLane = 1;
  localparam int BrightLane = 3;
  localparam logic [13:0] Max5 = 14'd31;
  localparam logic [13:0] Max6 = 14'd63;
  localparam logic [14:0] Pct = 15'd100;

  logic [13:0]     x1_q [NumCh];
  logic [13:0]     x2_q [NumCh];
  logic [ChW-1:0]  est2_q [NumCh];
  logic [ChW-1:0]  e3_q [NumCh];
  logic [14:0]     y4_q [NumLanes];
  logic [14:0]     y5_q [NumLanes];
  logic [ChW-1:0]  est5_q [NumLanes];
  logic [ChW-1:0]  out6_q [NumLanes];
  logic [PctW-1:0] l1_q, l2_q, l3_q;

  logic [19:0]     ep [NumCh];
  logic [ChW-1:0]  est [NumCh];
  logic [13:0]     rem [NumCh];
  logic [13:0]     cmax [NumCh];
  logic [23:0]     yp [NumLanes];
  logic [14:0]     yrem [NumLanes];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      x1_q[0] <= 14'(red5_i) * 14'd255;
      x1_q[1] <= 14'(green6_i) * 14'd255;
      x1_q[2] <= 14'(blue5_i) * 14'd255;
      l1_q    <= level_pct_i;
    end
  end

  // Reciprocal estimates sit at most one below the true quotient.
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      if (i == GreenLane) begin
        ep[i]  = 20'(x1_q[i]) * 20'd65;
        est[i] = ep[i][19:12];
      end else begin
        ep[i]  = 20'(x1_q[i]) * 20'd33;
        est[i] = ep[i][17:10];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      for (int i = 0; i < NumCh; i++) begin
        x2_q[i]   <= x1_q[i];
        est2_q[i] <= est[i];
      end
      l2_q <= l1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      cmax[i] = (i == GreenLane) ? Max6 : Max5;
      rem[i]  = x2_q[i] - 14'(est2_q[i]) * cmax[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      for (int i = 0; i < NumCh; i++) begin
        e3_q[i] <= est2_q[i] + ChW'(rem[i] >= cmax[i]);
      end
      l3_q <= l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      for (int i = 0; i < NumCh; i++) begin
        y4_q[i] <= 15'(e3_q[i]) * 15'(l3_q);
      end
      y4_q[BrightLane] <= 15'(l3_q) * 15'd255;
    end
  end

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      yp[i] = 24'(y4_q[i]) * 24'd655;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      for (int i = 0; i < NumLanes; i++) begin
        y5_q[i]   <= y4_q[i];
        est5_q[i] <= yp[i][23:16];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      yrem[i] = y5_q[i] - 15'(est5_q[i]) * Pct;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      for (int i = 0; i < NumLanes; i++) begin
        out6_q[i] <= est5_q[i] + ChW'(yrem[i] >= Pct);
      end
    end
  end

  assign red_out_o     = out6_q[0];
  assign green_out_o   = out6_q[GreenLane];
  assign blue_out_o    = out6_q[2];
  assign bright_byte_o = out6_q[BrightLane];

endmodule

@@ hw/rtl/hsv_to_rgb565_level_scaler.sv @@
// Top level of the HSV to RGB565 converter with brightness level scaling.
//
// A request on in_i carries a hue, saturation, value and level percent; each request
// yields exactly one request on out_o with the RGB565 word, the three expanded
// channels scaled by the level, and the brightness byte.
// Both channels use valid and ready; a request moves when both are high.
// The datapath is a ten-stage pipeline: four stages convert HSV to RGB565 and six
// expand the channels and scale them by the level. A result passes through every
// stage before it shows on out_o, and one request is taken every cycle unless every
// stage is full and out_o is not ready.
// Each stage holds its own valid bit and advances when it is empty or the next
// stage advances, so empty slots close up while the receiver stalls. A stalled
// result is held unchanged on out_o until it is taken, and ready on in_i drops
// only once every stage is full.
// Reset clears all valid bits; the pipeline is empty and ready after reset.
module hsv_to_rgb565_level_scaler (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsvrgb_in_if.sink    in_i,
  hsvrgb_out_if.source out_o
);
  import hsvrgb_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;
  logic [PctW-1:0]      lvl_q [HsvStages];
  logic [4:0]           red5, blue5;
  logic [5:0]           green6;
  logic [Rgb565W-1:0]   packed_hsv;
  logic [Rgb565W-1:0]   packed_q [ScaleStages];

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lvl_q[0] <= pct_clamp(in_i.level_pct);
    end
    for (int k = 1; k < HsvStages; k++) begin
      if (adv[k]) begin
        lvl_q[k] <= lvl_q[k-1];
      end
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = vld_q[NumStages-1];

  hsvrgb_convert u_convert (
    .clk_i          (clk_i),
    .adv_i          (adv[HsvStages-1:0]),
    .hue_frac_i     (in_i.hue_frac),
    .sat_level_i    (in_i.sat_level),
    .val_level_i    (in_i.val_level),
    .packed_color_o (packed_hsv),
    .red5_o         (red5),
    .green6_o       (green6),
    .blue5_o        (blue5)
  );

  always_ff @(posedge clk_i) begin
    if (adv[HsvStages]) begin
      packed_q[0] <= packed_hsv;
    end
    for (int k = 1; k < ScaleStages; k++) begin
      if (adv[HsvStages+k]) begin
        packed_q[k] <= packed_q[k-1];
      end
    end
  end

  assign out_o.packed_color = packed_q[ScaleStages-1];

  hsvrgb_scale u_scale (
    .clk_i         (clk_i),
    .adv_i         (adv[NumStages-1:HsvStages]),
    .red5_i        (red5),
    .green6_i      (green6),
    .blue5_i       (blue5),
    .level_pct_i   (lvl_q[HsvStages-1]),
    .red_out_o     (out_o.red_out),
    .green_out_o   (out_o.green_out),
    .blue_out_o    (out_o.blue_out),
    .bright_byte_o (out_o.bright_byte)
  );

endmodule

@@ sim/tb_hsv_to_rgb565_level_scaler.sv @@
// Testbench that checks the HSV to RGB565 level scaler against its own color predictor.
module tb_hsv_to_rgb565_level_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;

  localparam int ClkHalf = 2;
  localparam int ResetCycles = 8;
  localparam int RandItems = 850;
  localparam int NumPhases = 4;
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 200000;
  localparam int MaxReported = 10;
  localparam int NumDir = 22;

  localparam longint unsigned ChanMax = 255;
  localparam longint unsigned Max5 = 31;
  localparam longint unsigned Max6 = 63;
  localparam longint unsigned PctMax = 100;
  localparam longint unsigned SvMax = 256;

  typedef struct packed {
    logic [HueW-1:0] hue_frac;
    logic [SvW-1:0]  sat_level;
    logic [SvW-1:0]  val_level;
    logic [PctW-1:0] level_pct;
  } hsv_req_t;

  typedef struct packed {
    logic [Rgb565W-1:0] packed_color;
    logic [ChW-1:0]     red_out;
    logic [ChW-1:0]     green_out;
    logic [ChW-1:0]     blue_out;
    logic [ChW-1:0]     bright_byte;
  } rgb_res_t;

  typedef struct packed {
    hsv_req_t req;
    logic     known;
    rgb_res_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  hsvrgb_in_if  in_if ();
  hsvrgb_out_if out_if ();

  hsv_to_rgb565_level_scaler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rgb_res_t pending_colors[$];
  int       bad_fields;
  int       cycles;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_req;

  dir_row_t dir_rows [NumDir] = '{
    '{'{16'd0,     9'd0,   9'd0,   7'd0},   1'b1, '{16'h0000, 8'd0,   8'd0,   8'd0,   8'd0}},
    '{'{16'd0,     9'd0,   9'd256, 7'd100}, 1'b1, '{16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{16'd0,     9'd256, 9'd256, 7'd100}, 1'b1, '{16'hF800, 8'd255, 8'd0,   8'd0,   8'd255}},
    '{'{16'd0,     9'd511, 9'd511, 7'd127}, 1'b1, '{16'hF800, 8'd255, 8'd0,   8'd0,   8'd255}},
    '{'{16'd0,     9'd256, 9'd256, 7'd0},   1'b1, '{16'hF800, 8'd0,   8'd0,   8'd0,   8'd0}},
    '{'{16'd0,     9'd256, 9'd256, 7'd50},  1'b1, '{16'hF800, 8'd127, 8'd0,   8'd0,   8'd127}},
    '{'{16'd0,     9'd256, 9'd256, 7'd1},   1'b1, '{16'hF800, 8'd2,   8'd0,   8'd0,   8'd2}},
    '{'{16'd0,     9'd300, 9'd257, 7'd101}, 1'b1, '{16'hF800, 8'd255, 8'd0,   8'd0,   8'd255}},
    '{'{16'd10922, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd10923, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd21845, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd21846, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd32768, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd43691, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd54613, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'd54614, 9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'hFFFF,  9'd256, 9'd256, 7'd100}, 1'b0, '0},
    '{'{16'hFFFF,  9'h1FF, 9'h1FF, 7'h7F},  1'b0, '0},
    '{'{16'h5555,  9'd128, 9'd200, 7'd73},  1'b0, '0},
    '{'{16'h8000,  9'd1,   9'd1,   7'd1},   1'b0, '0},
    '{'{16'h2AAA,  9'd255, 9'd255, 7'd99},  1'b0, '0},
    '{'{16'hC001,  9'd64,  9'd256, 7'd100}, 1'b0, '0}
  };

  function automatic rgb_res_t hsv_to_rgb_levels(hsv_req_t req);
    longint unsigned hue, s, v, lvl, h6, f;
    longint unsigned cv, cp, cq, ct, r, g, b, r5, g6, b5;
    logic [2:0]      sector;
    rgb_res_t        res;
    hue = req.hue_frac;
    s = (req.sat_level > SvMax) ? SvMax : req.sat_level;
    v = (req.val_level > SvMax) ? SvMax : req.val_level;
    lvl = (req.level_pct > PctMax) ? PctMax : req.level_pct;
    h6 = hue * 6;
    sector = 3'(h6 >> 16);
    f = h6 & 64'hFFFF;
    cv = (v * ChanMax) >> 8;
    cp = (v * (SvMax - s) * ChanMax) >> 16;
    cq = (v * ((64'd1 << 24) - f * s) * ChanMax) >> 32;
    ct = (v * ((64'd1 << 24) - (64'd65536 - f) * s) * ChanMax) >> 32;
    case (sector)
      SecRedYel: begin r = cv; g = ct; b = cp; end
      SecYelGrn: begin r = cq; g = cv; b = cp; end
      SecGrnCyn: begin r = cp; g = cv; b = ct; end
      SecCynBlu: begin r = cp; g = cq; b = cv; end
      SecBluMag: begin r = ct; g = cp; b = cv; end
      default:   begin r = cv; g = cp; b = cq; end
    endcase
    r5 = (r & ChanMax) >> 3;
    g6 = (g & ChanMax) >> 2;
    b5 = (b & ChanMax) >> 3;
    res.packed_color = Rgb565W'((r5 << 11) | (g6 << 5) | b5);
    res.red_out = ChW'((r5 * ChanMax / Max5) * lvl / PctMax);
    res.green_out = ChW'((g6 * ChanMax / Max6) * lvl / PctMax);
    res.blue_out = ChW'((b5 * ChanMax / Max5) * lvl / PctMax);
    res.bright_byte = ChW'(lvl * ChanMax / PctMax);
    return res;
  endfunction

  function automatic hsv_req_t random_hsv();
    hsv_req_t req;
    req.hue_frac = HueW'($urandom);
    req.sat_level = ($urandom_range(0, 3) == 0) ? SvW'($urandom_range(0, 511))
                                                : SvW'($urandom_range(0, 256));
    req.val_level = ($urandom_range(0, 3) == 0) ? SvW'($urandom_range(0, 511))
                                                : SvW'($urandom_range(0, 256));
    req.level_pct = ($urandom_range(0, 3) == 0) ? PctW'($urandom_range(0, 127))
                                                : PctW'($urandom_range(0, 100));
    return req;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      bad_fields++;
      if (bad_fields <= MaxReported) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_val, act_val);
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_color(hsv_req_t req, rgb_res_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.hue_frac <= req.hue_frac;
    in_if.sat_level <= req.sat_level;
    in_if.val_level <= req.val_level;
    in_if.level_pct <= req.level_pct;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    pending_colors.push_back(res);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever begin
      #ClkHalf clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rgb_res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_colors.size() == 0) begin
        bad_fields++;
        if (bad_fields <= MaxReported) begin
          $display("%0t: result %0h with no request waiting", $realtime, out_if.packed_color);
        end
      end else begin
        exp_res = pending_colors.pop_front();
        check_field("packed_color", exp_res.packed_color, out_if.packed_color);
        check_field("red_out", 16'(exp_res.red_out), 16'(out_if.red_out));
        check_field("green_out", 16'(exp_res.green_out), 16'(out_if.green_out));
        check_field("blue_out", 16'(exp_res.blue_out), 16'(out_if.blue_out));
        check_field("bright_byte", 16'(exp_res.bright_byte), 16'(out_if.bright_byte));
      end
    end
  end

  initial begin
    int hold_left;
    out_if.ready = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    hsv_req_t req;
    bad_fields = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.hue_frac = '0;
    in_if.sat_level = '0;
    in_if.val_level = '0;
    in_if.level_pct = '0;
    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_color(dir_rows[i].req, dir_rows[i].known ? dir_rows[i].res
                                                    : hsv_to_rgb_levels(dir_rows[i].req));
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (RandItems / NumPhases) begin
        req = random_hsv();
        send_color(req, hsv_to_rgb_levels(req));
      end
    end
    in_if.valid <= 1'b0;

    while (pending_colors.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (NumStages + 10) @(posedge clk_i);

    if (bad_fields == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
